[hdl/vha_pkg.sv]
package vha_pkg;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned HEADING_W  = 17;
  localparam int unsigned TABLE_FRAC = 20;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned Z_W        = 28;
  localparam int unsigned TAB_W      = 27;

  typedef struct packed {
    logic signed [VEL_W-1:0] x_velocity;
    logic signed [VEL_W-1:0] y_velocity;
  } vha_in_t;

  typedef struct packed {
    logic signed [HEADING_W-1:0] heading;
    logic                        held;
  } vha_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } vha_ctrl_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic [TAB_W-1:0] atan_entry(input logic [4:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 27'd47185920;
      5'd1:    v = 27'd27855475;
      5'd2:    v = 27'd14718068;
      5'd3:    v = 27'd7471121;
      5'd4:    v = 27'd3750058;
      5'd5:    v = 27'd1876857;
      5'd6:    v = 27'd938658;
      5'd7:    v = 27'd469357;
      5'd8:    v = 27'd234682;
      5'd9:    v = 27'd117342;
      5'd10:   v = 27'd58671;
      5'd11:   v = 27'd29335;
      5'd12:   v = 27'd14668;
      5'd13:   v = 27'd7334;
      5'd14:   v = 27'd3667;
      5'd15:   v = 27'd1833;
      5'd16:   v = 27'd917;
      5'd17:   v = 27'd458;
      5'd18:   v = 27'd229;
      5'd19:   v = 27'd115;
      5'd20:   v = 27'd57;
      5'd21:   v = 27'd29;
      5'd22:   v = 27'd14;
      5'd23:   v = 27'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/velocity_heading_angle.sv]
// Sequence: after an accept ST_RUN steps the vectoring loop, then ST_FIN loads the output
//   register; a zero vector goes from ST_IDLE straight to ST_FIN. The one-step-per-cycle
//   vectoring loop in vha_cordic sets the pace; input is not ready until ST_FIN is left.
// A result that waits in the output register holds off the final step only.
// Reset: asynchronous, active low; clears the sequencer, output valid and the
//   stored heading (0).
module velocity_heading_angle #(
  parameter int unsigned VELOCITY_BITS   = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 7,
  parameter int unsigned ITERATIONS      = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vha_pkg::vha_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vha_pkg::vha_out_t out_data_o
);
  import vha_pkg::*;

  localparam int unsigned VW  = VELOCITY_BITS;
  localparam int unsigned IW  = $clog2(ITERATIONS);
  localparam int unsigned HSW = ANGLE_FRAC_BITS + 11;
  localparam int unsigned SH  = TABLE_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [Z_W-1:0] RND   = Z_W'(1) << (SH - 1);
  localparam logic signed [Z_W-1:0] RIGHT = Z_W'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [HSW-1:0] HALF  = HSW'(180) << ANGLE_FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          x_neg_q, y_pos_q, zero_q;
  logic          out_valid_q, out_valid_d, held_q, held_d;
  logic signed [HEADING_W-1:0] last_q, last_d;

  logic signed [VW-1:0] x_s, y_s;
  logic [VW-1:0]        mag_x, mag_y;
  logic                 accept, fin_go;
  vha_ctrl_t            ctrl;
  logic signed [Z_W-1:0] z, zr, t;
  logic signed [HSW-1:0] tc, h;

  if (VW <= VEL_W) begin : g_narrow
    assign x_s = signed'(in_data_i.x_velocity[VW-1:0]);
    assign y_s = signed'(in_data_i.y_velocity[VW-1:0]);
  end else begin : g_wide
    assign x_s = signed'({{(VW-VEL_W){1'b0}}, in_data_i.x_velocity});
    assign y_s = signed'({{(VW-VEL_W){1'b0}}, in_data_i.y_velocity});
  end

  assign mag_x  = x_s[VW-1] ? VW'(-x_s) : VW'(x_s);
  assign mag_y  = y_s[VW-1] ? VW'(-y_s) : VW'(y_s);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign ctrl.load = accept;
  assign ctrl.step = (state_q == ST_RUN);

  vha_cordic #(
    .VW (VW),
    .IT (ITERATIONS),
    .IW (IW)
  ) u_cordic (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .mag_a_i (mag_y),
    .mag_b_i (mag_x),
    .idx_i   (cnt_q),
    .z_o     (z)
  );

  always_comb begin
    zr = z + RND;
    t  = zr >>> SH;
    if (t < 0) begin
      t = '0;
    end
    if (t > RIGHT) begin
      t = RIGHT;
    end
    if (y_pos_q && (t > RIGHT - 1)) begin
      t = RIGHT - 1;
    end
    tc = HSW'(t);
    if (y_pos_q) begin
      h = x_neg_q ? HALF + tc : HALF - tc;
    end else begin
      h = x_neg_q ? -tc : tc;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    held_d      = held_q;
    last_d      = last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = (x_s == '0 && y_s == '0) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(ITERATIONS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          held_d      = zero_q;
          if (!zero_q) begin
            last_d = HEADING_W'(h);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      held_q      <= 1'b0;
      last_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_neg_q <= x_s[VW-1];
      y_pos_q <= !y_s[VW-1] && (y_s != '0);
      zero_q  <= (x_s == '0) && (y_s == '0);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o.heading = last_q;
  assign out_data_o.held    = held_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input ready right after an accept");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("output valid raised outside the final step");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o && in_ready_o)
    else $error("final step did not load the output register");

  a_heading_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FIN) |=> $stable(last_q))
    else $error("stored heading changed outside the final step");
`endif

endmodule

[hdl/vha_cordic.sv]
module vha_cordic #(
  parameter int unsigned VW = 16,
  parameter int unsigned IT = 16,
  parameter int unsigned IW = 4
) (
  input  logic                         clk_i,
  input  vha_pkg::vha_ctrl_t           ctrl_i,
  input  logic [VW-1:0]                mag_a_i,
  input  logic [VW-1:0]                mag_b_i,
  input  logic [IW-1:0]                idx_i,
  output logic signed [vha_pkg::Z_W-1:0] z_o
);
  import vha_pkg::*;

  localparam int unsigned W = VW + IT + 2;

  logic signed [W-1:0]   a_q, a_d, b_q, b_d, da, db;
  logic signed [Z_W-1:0] z_q, z_d, ang;

  always_comb begin
    da  = b_q >>> idx_i;
    db  = a_q >>> idx_i;
    ang = signed'({1'b0, atan_entry(5'(idx_i))});
    a_d = a_q;
    b_d = b_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      a_d = signed'({2'b00, mag_a_i, {IT{1'b0}}});
      b_d = signed'({2'b00, mag_b_i, {IT{1'b0}}});
      z_d = '0;
    end else if (ctrl_i.step) begin
      if (!b_q[W-1]) begin
        a_d = a_q + da;
        b_d = b_q - db;
        z_d = z_q + ang;
      end else begin
        a_d = a_q - da;
        b_d = b_q + db;
        z_d = z_q - ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    z_q <= z_d;
  end

  assign z_o = z_q;

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vha_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_FRAC   = 7;
  localparam int ATAN_FRAC    = 20;
  localparam longint RIGHT_ANGLE = longint'(90) << ANGLE_FRAC;
  localparam longint HALF_TURN   = longint'(180) << ANGLE_FRAC;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int SHOWN_MISMATCHES = 10;

  // atan(2^-i) in 2^-20 degree
  localparam longint ATAN_STEP [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  class heading_board;
    vha_out_t                    expected_q[$];
    logic signed [HEADING_W-1:0] stored_heading;
    int                          failures;

    function new();
      stored_heading = '0;
      failures       = 0;
    endfunction

    // angle of (a, b) from the a axis, a and b non-negative, in 2^-20 degree
    function longint vector_angle(longint a, longint b);
      longint z;
      longint da;
      longint db;
      z = 0;
      a = a << CORDIC_STEPS;
      b = b << CORDIC_STEPS;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        da = b >>> i;
        db = a >>> i;
        if (b >= 0) begin
          a = a + da;
          b = b - db;
          z = z + ATAN_STEP[i];
        end else begin
          a = a - da;
          b = b + db;
          z = z - ATAN_STEP[i];
        end
      end
      return z;
    endfunction

    function void note_input(vha_in_t item);
      longint   x;
      longint   y;
      longint   t;
      longint   h;
      vha_out_t exp_item;
      x = item.x_velocity;
      y = item.y_velocity;
      if (x == 0 && y == 0) begin
        exp_item.heading = stored_heading;
        exp_item.held    = 1'b1;
      end else begin
        t = vector_angle((y < 0) ? -y : y, (x < 0) ? -x : x);
        t = (t + (longint'(1) << (ATAN_FRAC - 1 - ANGLE_FRAC))) >>> (ATAN_FRAC - ANGLE_FRAC);
        if (t < 0) t = 0;
        if (t > RIGHT_ANGLE) t = RIGHT_ANGLE;
        if (y <= 0) begin
          h = (x < 0) ? -t : t;
        end else begin
          if (t > RIGHT_ANGLE - 1) t = RIGHT_ANGLE - 1;
          h = (x < 0) ? HALF_TURN + t : HALF_TURN - t;
        end
        stored_heading   = h[HEADING_W-1:0];
        exp_item.heading = stored_heading;
        exp_item.held    = 1'b0;
      end
      expected_q.push_back(exp_item);
    endfunction

    function void check_result(vha_out_t got);
      vha_out_t exp_item;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES)
          $display("unexpected result: heading %0d held %0b", got.heading, got.held);
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.heading !== exp_item.heading || got.held !== exp_item.held) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES)
          $display("mismatch: heading exp %0d got %0d, held exp %0b got %0b",
                   exp_item.heading, got.heading, exp_item.held, got.held);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  vha_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  vha_out_t out_data_o;

  int send_idle_pct = 20;
  int recv_idle_pct = 81;

  heading_board board;

  velocity_heading_angle DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(out_data_o);
    end
  end

  task automatic send_item(input vha_in_t item);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) begin
      in_valid_i <= 1'b0;
    end
    while (idle) begin
      @(posedge clk_i);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(item);
  endtask

  task automatic send_xy(input int x, input int y);
    vha_in_t item;
    item.x_velocity = x[VEL_W-1:0];
    item.y_velocity = y[VEL_W-1:0];
    send_item(item);
  endtask

  function automatic int pick_component();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 32767;
      1:       return -32768;
      2:       return -32767;
      3:       return 1;
      4:       return -1;
      5:       return 0;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic vha_in_t random_vector();
    vha_in_t item;
    int      mode;
    mode = $urandom_range(99);
    item.x_velocity = VEL_W'($urandom());
    item.y_velocity = VEL_W'($urandom());
    if (mode < 5) begin
      item = '0;
    end else if (mode < 10) begin
      item.x_velocity = '0;
    end else if (mode < 15) begin
      item.y_velocity = '0;
    end else if (mode < 55) begin
      // full range, already set
    end else if (mode < 75) begin
      item.x_velocity = VEL_W'(int'($urandom_range(32)) - 16);
      item.y_velocity = VEL_W'(int'($urandom_range(32)) - 16);
    end else if (mode < 85) begin
      item.y_velocity = VEL_W'(int'($urandom_range(6)) - 3);
    end else begin
      item.x_velocity = VEL_W'(pick_component());
      item.y_velocity = VEL_W'(pick_component());
    end
    return item;
  endfunction

  initial begin
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_xy(0, 0);
    send_xy(0, -1);
    send_xy(0, 1);
    send_xy(1, 0);
    send_xy(-1, 0);
    send_xy(0, 0);
    send_xy(32767, 0);
    send_xy(-32768, 0);
    send_xy(0, -32768);
    send_xy(0, 32767);
    send_xy(32767, -32768);
    send_xy(-32768, -32768);
    send_xy(32767, 32767);
    send_xy(-32768, 32767);
    send_xy(32767, 1);
    send_xy(-32768, 1);
    send_xy(1, -1);
    send_xy(-1, 1);
    send_xy(0, 0);
    send_xy(0, 0);
    send_xy(5, -3);
    send_xy(-7, 12);
    send_xy(16'sh5555, -21846);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(random_vector());
    end

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (CORDIC_STEPS + 10) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
